// File: rtl/isbkd_pkg.sv
// Shared types and constants for the descending index sort block.
`default_nettype none
package isbkd_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 6;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx;
    logic                    store;
    logic                    last;
    logic                    ovf;
  } q_entry_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/isbkd_if.sv
// Valid/ready channel interfaces for the input items and the sorted results.
`default_nettype none
interface isbkd_in_if;
  import isbkd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] key;
  logic                    last;
  modport source (output valid, key, last, input ready);
  modport sink (input valid, key, last, output ready);
endinterface

interface isbkd_out_if;
  import isbkd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] sorted_key;
  logic                    final_result;
  logic                    overflowed;
  modport source (output valid, entry_index, sorted_key, final_result, overflowed,
                  input ready);
  modport sink (input valid, entry_index, sorted_key, final_result, overflowed,
                output ready);
endinterface
`default_nettype wire

// File: rtl/isbkd_front.sv
// Front end: numbers incoming keys, tracks the fill level and flags overflow.
`default_nettype none
module isbkd_front #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  isbkd_in_if.sink          items,
  output isbkd_pkg::q_entry_t push_data,
  output logic              push_valid,
  input  wire logic         push_ready
);
  import isbkd_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             full;
  logic             accept;

  assign items.ready = push_ready;
  assign push_valid  = items.valid;
  assign accept      = items.valid && push_ready;
  assign full        = (count == CNT_W'(MAX_ENTRIES));

  always_comb begin
    push_data.key   = items.key;
    push_data.idx   = IDX_W'(count);
    push_data.store = !full;
    push_data.last  = items.last;
    push_data.ovf   = ovf || full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (accept) begin
      if (items.last) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/isbkd_queue.sv
// Small FIFO that decouples the front end from the sorting back end.
`default_nettype none
module isbkd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire isbkd_pkg::q_entry_t push_data,
  input  wire logic           push_valid,
  output logic                push_ready,
  output isbkd_pkg::q_entry_t pop_data,
  output logic                pop_valid,
  input  wire logic           pop_ready
);
  import isbkd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/isbkd_back.sv
// Back end: insertion chain that keeps entries sorted, then shifts them out.
`default_nettype none
module isbkd_back #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire isbkd_pkg::q_entry_t pop_data,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  isbkd_out_if.source         results
);
  import isbkd_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [MAX_ENTRIES-1:0]  cvalid;
  logic signed [KEY_W-1:0] ckey [MAX_ENTRIES];
  logic [IDX_W-1:0]        cidx [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  gt;

  logic pop;
  logic insert;
  logic shift;
  logic run_ovf;

  logic                    out_valid;
  logic [IDX_W-1:0]        out_idx;
  logic signed [KEY_W-1:0] out_key;
  logic                    out_final;
  logic                    out_ovf;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (pop && pop_data.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (shift && !cvalid[1]) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    pop_ready = 1'b0;
    shift     = 1'b0;
    unique case (state)
      ST_LOAD:  pop_ready = 1'b1;
      ST_DRAIN: shift = !out_valid || results.ready;
      default: begin
        pop_ready = 1'b0;
        shift     = 1'b0;
      end
    endcase
  end

  assign pop    = pop_valid && pop_ready;
  assign insert = pop && pop_data.store;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // A new key lands ahead of every strictly smaller key, so equal keys keep
  // arrival order. Empty cells count as smaller than anything.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign gt[i] = !cvalid[i] || (pop_data.key > ckey[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        cvalid[i] <= 1'b0;
      end else if (shift) begin
        cvalid[i] <= (i < MAX_ENTRIES - 1) ? cvalid[(i + 1) % MAX_ENTRIES] : 1'b0;
      end else if (insert) begin
        if (i > 0 && gt[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]) begin
          cvalid[i] <= cvalid[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
        end else if (gt[i]) begin
          cvalid[i] <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (shift) begin
        if (i < MAX_ENTRIES - 1) begin
          ckey[i] <= ckey[(i + 1) % MAX_ENTRIES];
          cidx[i] <= cidx[(i + 1) % MAX_ENTRIES];
        end
      end else if (insert) begin
        if (i > 0 && gt[(i + MAX_ENTRIES - 1) % MAX_ENTRIES]) begin
          ckey[i] <= ckey[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
          cidx[i] <= cidx[(i + MAX_ENTRIES - 1) % MAX_ENTRIES];
        end else if (gt[i]) begin
          ckey[i] <= pop_data.key;
          cidx[i] <= pop_data.idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_data.last) begin
      run_ovf <= pop_data.ovf;
    end
  end

  // Output register; it is refilled from the head of the chain on a shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (shift) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      out_idx   <= cidx[0];
      out_key   <= ckey[0];
      out_final <= !cvalid[1];
      out_ovf   <= run_ovf;
    end
  end

  assign results.valid        = out_valid;
  assign results.entry_index  = out_idx;
  assign results.sorted_key   = out_key;
  assign results.final_result = out_final;
  assign results.overflowed   = out_ovf;

endmodule
`default_nettype wire

// File: rtl/index_sort_by_key_descending_top.sv
// With the queue empty, the first result of a set is loaded into the output
// register after the last item has passed through the queue into the chain.
// Throughput: keys are taken one per cycle while the queue has room; results
// leave one per cycle while the sink is ready. A set occupies the insertion
// chain while it loads and while it drains; the next set may queue meanwhile.
// Reset: synchronous and active high; it empties the queue and the chain.
`default_nettype none
module index_sort_by_key_descending_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  isbkd_in_if.sink    items,
  isbkd_out_if.source results
);
  import isbkd_pkg::*;

  q_entry_t push_data;
  logic     push_valid;
  logic     push_ready;
  q_entry_t pop_data;
  logic     pop_valid;
  logic     pop_ready;

  isbkd_front #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready)
  );

  isbkd_queue #(
    .DEPTH(4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_data (push_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready)
  );

  isbkd_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .results  (results)
  );

endmodule
`default_nettype wire

// File: rtl/isbkd_checker.sv
// Port-level checks of the sorted result stream, bound to the top level.
`default_nettype none
module isbkd_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_index,
  input wire logic signed [31:0] out_key,
  input wire logic        out_final
);

  logic                in_run;
  logic signed [31:0]  prev_key;
  logic [5:0]          prev_idx;
  logic                out_fire;

  assign out_fire = out_valid && out_ready;

  // Remember the previous transfer of the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (out_fire) begin
      in_run <= !out_final;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_key <= out_key;
      prev_idx <= out_index;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_descending: assert property (@(posedge clk) disable iff (rst)
    out_fire && in_run |-> out_key <= prev_key)
    else $error("keys not in descending order");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_fire && in_run && out_key == prev_key |-> out_index > prev_idx)
    else $error("equal keys out of arrival order");

endmodule

bind index_sort_by_key_descending_top isbkd_props u_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_index(results.entry_index),
  .out_key  (results.sorted_key),
  .out_final(results.final_result)
);
`default_nettype wire
